// ===== rtl/lav_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lav_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_IN          = 9;
    localparam int IN_W          = N_IN * DATA_W;
    localparam int OUT_W         = 4 * DATA_W;
    localparam int USER_W        = 3;

    // normalizer datapath
    localparam int MAG_W  = 30;
    localparam int SUM_W  = 2 * MAG_W + 2;
    localparam int ROOT_W = MAG_W + 1;
    localparam int REM_W  = ROOT_W + 1;
    localparam int NORM_FIXED_LAT = 5 + ROOT_W + 1 + 1 + 1;

    typedef enum logic [1:0] {
        ROW_RIGHT,
        ROW_UP,
        ROW_FWD
    } row_t;

    function automatic int norm_lat(input int fb);
        return fb + NORM_FIXED_LAT;
    endfunction

    // clamp a 33-bit signed value (never below -2^31) to the positive 32-bit limit
    function automatic logic [DATA_W-1:0] sat_pos(input logic signed [DATA_W:0] v);
        logic signed [DATA_W:0] lim;
        lim = $signed({2'b00, {(DATA_W-1){1'b1}}});
        return (v > lim) ? {1'b0, {(DATA_W-1){1'b1}}} : v[DATA_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/lav_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lav_delay
    import lav_pkg::*;
#(
    parameter int W = 1,
    parameter int N = 1
) (
    input  logic         aclk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] sr_reg [0:N-1];

    always_ff @(posedge aclk) begin
        if (en) begin
            sr_reg[0] <= din;
            for (int k = 1; k < N; k++) begin
                sr_reg[k] <= sr_reg[k-1];
            end
        end
    end

    assign dout = sr_reg[N-1];

endmodule

`default_nettype wire

// ===== rtl/lav_cross.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lav_cross
    import lav_pkg::*;
#(
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [2:0][FB+1:0]         a,
    input  logic [2:0][FB+1:0]         b,
    output logic [2:0][2*FB+2:0]       c
);

    localparam int PRW = 2 * FB + 4;
    localparam int CW  = 2 * FB + 3;

    logic signed [PRW-1:0] p_reg [0:5];
    logic [2:0][CW-1:0]    c_reg;
    logic signed [PRW-1:0] diff_w [0:2];

    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg[0] <= $signed(a[1]) * $signed(b[2]);
            p_reg[1] <= $signed(a[2]) * $signed(b[1]);
            p_reg[2] <= $signed(a[2]) * $signed(b[0]);
            p_reg[3] <= $signed(a[0]) * $signed(b[2]);
            p_reg[4] <= $signed(a[0]) * $signed(b[1]);
            p_reg[5] <= $signed(a[1]) * $signed(b[0]);
        end
    end

    always_comb begin
        diff_w[0] = p_reg[0] - p_reg[1];
        diff_w[1] = p_reg[2] - p_reg[3];
        diff_w[2] = p_reg[4] - p_reg[5];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                c_reg[i] <= diff_w[i][CW-1:0];
            end
        end
    end

    assign c = c_reg;

endmodule

`default_nettype wire

// ===== rtl/lav_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lav_norm
    import lav_pkg::*;
#(
    parameter int IW = 33,
    parameter int FB = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  en,
    input  logic [2:0][IW-1:0]    vec,
    output logic [2:0][FB+1:0]    unit,
    output logic                  zero
);

    localparam int PW = $clog2(IW);
    localparam int EW = IW + MAG_W;
    localparam int NW = MAG_W + FB + 1;
    localparam int QW = FB + 1;

    // magnitudes
    logic [2:0][IW-1:0] mag_reg;
    logic [2:0]         neg_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                neg_reg[i] <= vec[i][IW-1];
                mag_reg[i] <= vec[i][IW-1] ? (~vec[i] + IW'(1)) : vec[i];
            end
        end
    end

    // leading one
    logic [IW-1:0]      or_w;
    logic [PW-1:0]      pos_w;
    logic [2:0][IW-1:0] mag2_reg;
    logic [2:0]         neg2_reg;
    logic [PW-1:0]      pos_reg;
    logic               zero2_reg;

    always_comb begin
        or_w  = mag_reg[0] | mag_reg[1] | mag_reg[2];
        pos_w = '0;
        for (int k = 0; k < IW; k++) begin
            if (or_w[k]) begin
                pos_w = PW'(k);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            mag2_reg  <= mag_reg;
            neg2_reg  <= neg_reg;
            pos_reg   <= pos_w;
            zero2_reg <= (or_w == '0);
        end
    end

    // align largest into [2^29, 2^30)
    logic [2:0][EW-1:0]    ext_w;
    logic [2:0][EW-1:0]    sh_w;
    logic [7:0]            rsh_w;
    logic [7:0]            lsh_w;
    logic [2:0][MAG_W-1:0] mn_reg;
    logic [2:0]            neg3_reg;
    logic                  zero3_reg;

    always_comb begin
        rsh_w = 8'(pos_reg) - 8'(MAG_W - 1);
        lsh_w = 8'(MAG_W - 1) - 8'(pos_reg);
        for (int i = 0; i < 3; i++) begin
            ext_w[i] = {{MAG_W{1'b0}}, mag2_reg[i]};
            if (8'(pos_reg) >= 8'(MAG_W - 1)) begin
                sh_w[i] = ext_w[i] >> rsh_w;
            end else begin
                sh_w[i] = ext_w[i] << lsh_w;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                mn_reg[i] <= sh_w[i][MAG_W-1:0];
            end
            neg3_reg  <= neg2_reg;
            zero3_reg <= zero2_reg;
        end
    end

    // squares
    logic [2:0][2*MAG_W-1:0] sq_reg;
    logic [2:0][MAG_W-1:0]   m4_reg;
    logic [2:0]              neg4_reg;
    logic                    zero4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= mn_reg[i] * mn_reg[i];
            end
            m4_reg    <= mn_reg;
            neg4_reg  <= neg3_reg;
            zero4_reg <= zero3_reg;
        end
    end

    // sum feeds the root pipeline
    logic [SUM_W-1:0]      rem_p  [0:ROOT_W];
    logic [ROOT_W-1:0]     root_p [0:ROOT_W];
    logic [2:0][MAG_W-1:0] m_p    [0:ROOT_W];
    logic [2:0]            neg_p  [0:ROOT_W];
    logic                  zero_p [0:ROOT_W];

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_p[0]  <= SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2]);
            root_p[0] <= '0;
            m_p[0]    <= m4_reg;
            neg_p[0]  <= neg4_reg;
            zero_p[0] <= zero4_reg;
        end
    end

    for (genvar j = 0; j < ROOT_W; j++) begin : g_sqrt
        localparam int BI = ROOT_W - 1 - j;
        logic [SUM_W-1:0] trial_w;

        assign trial_w = (SUM_W'(root_p[j]) << (BI + 1)) | (SUM_W'(1) << (2 * BI));

        always_ff @(posedge aclk) begin
            if (en) begin
                if (rem_p[j] >= trial_w) begin
                    rem_p[j+1]  <= rem_p[j] - trial_w;
                    root_p[j+1] <= root_p[j] | (ROOT_W'(1) << BI);
                end else begin
                    rem_p[j+1]  <= rem_p[j];
                    root_p[j+1] <= root_p[j];
                end
                m_p[j+1]    <= m_p[j];
                neg_p[j+1]  <= neg_p[j];
                zero_p[j+1] <= zero_p[j];
            end
        end
    end

    // rounded quotient (m * 2^FB + s/2) / s
    logic [2:0][NW-1:0]    num_w;
    logic [2:0][REM_W-1:0] dr_p   [0:QW];
    logic [2:0][QW-1:0]    lo_p   [0:QW];
    logic [2:0][QW-1:0]    dq_p   [0:QW];
    logic [ROOT_W-1:0]     ds_p   [0:QW];
    logic [2:0]            dneg_p [0:QW];
    logic                  dzero_p[0:QW];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            num_w[i] = {1'b0, m_p[ROOT_W][i], {FB{1'b0}}} + NW'(root_p[ROOT_W] >> 1);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                dr_p[0][i] <= REM_W'(num_w[i][NW-1:QW]);
                lo_p[0][i] <= num_w[i][QW-1:0];
            end
            dq_p[0]    <= '0;
            ds_p[0]    <= root_p[ROOT_W];
            dneg_p[0]  <= neg_p[ROOT_W];
            dzero_p[0] <= zero_p[ROOT_W];
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_div
        localparam int BQ = QW - 1 - k;
        logic [2:0][REM_W-1:0] rr_w;
        logic [2:0]            ge_w;

        always_comb begin
            for (int i = 0; i < 3; i++) begin
                rr_w[i] = {dr_p[k][i][ROOT_W-1:0], lo_p[k][i][BQ]};
                ge_w[i] = (rr_w[i] >= {1'b0, ds_p[k]});
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                for (int i = 0; i < 3; i++) begin
                    if (ge_w[i]) begin
                        dr_p[k+1][i] <= rr_w[i] - {1'b0, ds_p[k]};
                        dq_p[k+1][i] <= dq_p[k][i] | (QW'(1) << BQ);
                    end else begin
                        dr_p[k+1][i] <= rr_w[i];
                        dq_p[k+1][i] <= dq_p[k][i];
                    end
                end
                lo_p[k+1]    <= lo_p[k];
                ds_p[k+1]    <= ds_p[k];
                dneg_p[k+1]  <= dneg_p[k];
                dzero_p[k+1] <= dzero_p[k];
            end
        end
    end

    // apply sign
    logic [2:0][FB+1:0] unit_reg;
    logic               zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                unit_reg[i] <= dneg_p[QW][i] ? -{1'b0, dq_p[QW][i]} : {1'b0, dq_p[QW][i]};
            end
            zero_reg <= dzero_p[QW];
        end
    end

    assign unit = unit_reg;
    assign zero = zero_reg;

endmodule

`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix in signed fixed point (FRAC_BITS fraction bits, Q16.16 by default).
// Each input transfer carries eye, target and up; the block returns three row transfers
// (right, true up, negated forward), each with three direction terms and the saturated
// translation, tlast on the third row. If target equals eye, up is zero or the vectors
// are parallel, all three rows are zero with the degenerate flag set. The datapath is a
// stall-able pipeline made of four normalizers, three of them in series, each with a
// one-bit-per-stage square root and divider; it takes a new item every cycle while the row
// buffer is empty or is sending its last row, and the sustained rate is limited by the three
// row transfers per item on the result channel.
`timescale 1ns / 1ps
`default_nettype none

module look_at_view_matrix
    import lav_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // elem_0, elem_1, elem_2, translation
    output logic [OUT_W-1:0]  m_axis_tdata,
    // row_index[1:0], degenerate[2]
    output logic [USER_W-1:0] m_axis_tuser,
    output logic              m_axis_tlast
);

    localparam int UW    = FRAC_BITS + 2;
    localparam int CW    = 2 * FRAC_BITS + 3;
    localparam int DW    = DATA_W + 1;
    localparam int NL    = norm_lat(FRAC_BITS);
    localparam int VL    = 3 * NL + 8;
    localparam int PRODW = UW + DATA_W;
    localparam int SUMW  = PRODW + 2;

    logic          adv;
    logic [VL-1:0] vld_reg;
    logic [VL-1:0] vld_next;

    // input stage
    logic [2:0][DATA_W-1:0] eye_reg;
    logic [2:0][DW-1:0]     d_reg;
    logic [2:0][DATA_W-1:0] up_reg;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                eye_reg[i] <= s_axis_tdata[i*DATA_W +: DATA_W];
                up_reg[i]  <= s_axis_tdata[(6+i)*DATA_W +: DATA_W];
                d_reg[i]   <= DW'($signed(s_axis_tdata[(3+i)*DATA_W +: DATA_W]))
                            - DW'($signed(s_axis_tdata[i*DATA_W +: DATA_W]));
            end
        end
    end

    // forward and up
    logic [2:0][UW-1:0] f_w, u_w;
    logic               zf_w, zu_w;

    lav_norm #(.IW(DW), .FB(FRAC_BITS)) u_norm_f (
        .aclk(aclk), .en(adv), .vec(d_reg), .unit(f_w), .zero(zf_w)
    );

    lav_norm #(.IW(DATA_W), .FB(FRAC_BITS)) u_norm_u (
        .aclk(aclk), .en(adv), .vec(up_reg), .unit(u_w), .zero(zu_w)
    );

    // right
    logic [2:0][CW-1:0] c1_w;
    logic [2:0][UW-1:0] r_w;
    logic               zr_w;

    lav_cross #(.FB(FRAC_BITS)) u_cross_fu (
        .aclk(aclk), .en(adv), .a(f_w), .b(u_w), .c(c1_w)
    );

    lav_norm #(.IW(CW), .FB(FRAC_BITS)) u_norm_r (
        .aclk(aclk), .en(adv), .vec(c1_w), .unit(r_w), .zero(zr_w)
    );

    logic [2:0][UW-1:0] f1_w, f2_w, r1_w;
    logic               deg1_w, deg2_w;

    lav_delay #(.W(3*UW), .N(NL+2)) u_dly_f1 (
        .aclk(aclk), .en(adv), .din(f_w), .dout(f1_w)
    );

    lav_delay #(.W(1), .N(NL+2)) u_dly_deg1 (
        .aclk(aclk), .en(adv), .din(zf_w | zu_w), .dout(deg1_w)
    );

    // true up
    logic [2:0][CW-1:0] c2_w;
    logic [2:0][UW-1:0] t_w;
    logic               zt_w;

    lav_cross #(.FB(FRAC_BITS)) u_cross_rf (
        .aclk(aclk), .en(adv), .a(r_w), .b(f1_w), .c(c2_w)
    );

    lav_norm #(.IW(CW), .FB(FRAC_BITS)) u_norm_t (
        .aclk(aclk), .en(adv), .vec(c2_w), .unit(t_w), .zero(zt_w)
    );

    lav_delay #(.W(3*UW), .N(NL+2)) u_dly_f2 (
        .aclk(aclk), .en(adv), .din(f1_w), .dout(f2_w)
    );

    lav_delay #(.W(3*UW), .N(NL+2)) u_dly_r (
        .aclk(aclk), .en(adv), .din(r_w), .dout(r1_w)
    );

    lav_delay #(.W(1), .N(NL+2)) u_dly_deg2 (
        .aclk(aclk), .en(adv), .din(deg1_w | zr_w), .dout(deg2_w)
    );

    logic [2:0][DATA_W-1:0] eye_d_w;

    lav_delay #(.W(3*DATA_W), .N(3*NL+4)) u_dly_eye (
        .aclk(aclk), .en(adv), .din(eye_reg), .dout(eye_d_w)
    );

    // translation: products, sum, round
    logic [2:0][2:0][UW-1:0]    dir_w;
    logic [2:0][2:0][UW-1:0]    dirp_reg, dirs_reg, dirr_reg;
    logic [2:0][2:0][PRODW-1:0] prod_reg;
    logic [2:0][SUMW-1:0]       sum_reg;
    logic [2:0][DATA_W-1:0]     q_reg;
    logic [2:0]                 qneg_reg;
    logic                       degp_reg, degs_reg, degr_reg;
    logic [2:0][SUMW-1:0]       mag_w, qw_w;
    logic [SUMW-1:0]            qlim_w;

    assign dir_w[ROW_RIGHT] = r1_w;
    assign dir_w[ROW_UP]    = t_w;
    assign dir_w[ROW_FWD]   = f2_w;

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                for (int j = 0; j < 3; j++) begin
                    prod_reg[k][j] <= $signed(dir_w[k][j]) * $signed(eye_d_w[j]);
                end
            end
            dirp_reg <= dir_w;
            degp_reg <= deg2_w | zt_w;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                sum_reg[k] <= SUMW'($signed(prod_reg[k][0])) + SUMW'($signed(prod_reg[k][1]))
                            + SUMW'($signed(prod_reg[k][2]));
            end
            dirs_reg <= dirp_reg;
            degs_reg <= degp_reg;
        end
    end

    always_comb begin
        qlim_w = SUMW'(1) << (DATA_W - 1);
        for (int k = 0; k < 3; k++) begin
            mag_w[k] = sum_reg[k][SUMW-1] ? (~sum_reg[k] + SUMW'(1)) : sum_reg[k];
            qw_w[k]  = (mag_w[k] + (SUMW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                q_reg[k]    <= (qw_w[k] > qlim_w) ? qlim_w[DATA_W-1:0] : qw_w[k][DATA_W-1:0];
                qneg_reg[k] <= sum_reg[k][SUMW-1];
            end
            dirr_reg <= dirs_reg;
            degr_reg <= degs_reg;
        end
    end

    // row buffer
    logic [2:0][DATA_W:0]           rf_w;
    logic [2:0][DATA_W-1:0]         dfix_w;
    logic [2:0][DATA_W-1:0]         tr_w;
    logic [2:0][2:0][DATA_W-1:0]    el_w;
    logic [2:0][2:0][DATA_W-1:0]    elem_reg;
    logic [2:0][DATA_W-1:0]         trans_reg;
    logic                           deg_reg;
    logic                           buf_valid_reg, buf_valid_next;
    row_t                           row_cnt_reg, row_cnt_next;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rf_w[k]   = qneg_reg[k] ? -{1'b0, q_reg[k]} : {1'b0, q_reg[k]};
            dfix_w[k] = sat_pos($signed(rf_w[k]));
            for (int j = 0; j < 3; j++) begin
                el_w[k][j] = DATA_W'($signed(dirr_reg[k][j]));
            end
        end
        tr_w[ROW_RIGHT] = sat_pos(-$signed({dfix_w[ROW_RIGHT][DATA_W-1], dfix_w[ROW_RIGHT]}));
        tr_w[ROW_UP]    = sat_pos(-$signed({dfix_w[ROW_UP][DATA_W-1], dfix_w[ROW_UP]}));
        tr_w[ROW_FWD]   = dfix_w[ROW_FWD];
        for (int j = 0; j < 3; j++) begin
            el_w[ROW_FWD][j] = DATA_W'(-$signed(dirr_reg[ROW_FWD][j]));
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && vld_reg[VL-1]) begin
            deg_reg <= degr_reg;
            if (degr_reg) begin
                elem_reg  <= '0;
                trans_reg <= '0;
            end else begin
                elem_reg  <= el_w;
                trans_reg <= tr_w;
            end
        end
    end

    // flow control
    always_comb begin
        adv            = !buf_valid_reg || (m_axis_tready && row_cnt_reg == ROW_FWD);
        vld_next       = vld_reg;
        buf_valid_next = buf_valid_reg;
        row_cnt_next   = row_cnt_reg;
        if (adv) begin
            vld_next       = {vld_reg[VL-2:0], s_axis_tvalid};
            buf_valid_next = vld_reg[VL-1];
        end
        if (buf_valid_reg && m_axis_tready) begin
            unique case (row_cnt_reg)
                ROW_RIGHT: row_cnt_next = ROW_UP;
                ROW_UP:    row_cnt_next = ROW_FWD;
                ROW_FWD:   row_cnt_next = ROW_RIGHT;
                default:   row_cnt_next = ROW_RIGHT;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            buf_valid_reg <= 1'b0;
            row_cnt_reg   <= ROW_RIGHT;
        end else begin
            vld_reg       <= vld_next;
            buf_valid_reg <= buf_valid_next;
            row_cnt_reg   <= row_cnt_next;
        end
    end

    assign s_axis_tready = adv;
    assign m_axis_tvalid = buf_valid_reg;
    assign m_axis_tdata  = {trans_reg[row_cnt_reg], elem_reg[row_cnt_reg][2],
                            elem_reg[row_cnt_reg][1], elem_reg[row_cnt_reg][0]};
    assign m_axis_tuser  = {deg_reg, row_cnt_reg};
    assign m_axis_tlast  = (row_cnt_reg == ROW_FWD);

    a_deg_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[2] |-> m_axis_tdata == '0)
        else $error("degenerate row carries data");

    a_row_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tready && m_axis_tlast |=> row_cnt_reg == ROW_RIGHT)
        else $error("row counter did not wrap after last row");

    a_empty_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        !buf_valid_reg |-> s_axis_tready)
        else $error("pipeline stalled with empty row buffer");

    a_load_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_axis_tvalid && $past(aresetn) && $past(vld_reg[VL-1]) && $past(adv) |-> 1'b0)
        else $error("finished item was dropped");

endmodule

`default_nettype wire
